/* rtl/b2n_pkg.sv */
// ----------------------------------------------------------------------------
// b2n_pkg
// Shared constants for the BGR to NV12 converter: register indexes, field
// widths, reset values and the BT.601 video-range coefficients.
// ----------------------------------------------------------------------------
package b2n_pkg;

    // Frame size limit and register width
    localparam int MaxDimDefault = 4096;
    localparam int CfgDataW      = 13;
    localparam int CfgIndexW     = 2;

    // Register indexes
    localparam logic [CfgIndexW-1:0] RegFrameWidth  = 2'd0;
    localparam logic [CfgIndexW-1:0] RegFrameHeight = 2'd1;

    // Register reset values
    localparam logic [CfgDataW-1:0] FrameWidthReset  = 13'd1920;
    localparam logic [CfgDataW-1:0] FrameHeightReset = 13'd1080;

    // Pixel and plane offset widths
    localparam int PixW       = 8;
    localparam int LumaAddrW  = 24;
    localparam int ChromaAddrW = 23;

    // Signed accumulator width for the color sums
    localparam int SumW = 18;

    // BT.601 video-range coefficients
    localparam logic signed [SumW-1:0] CoefYR = 18'sd66;
    localparam logic signed [SumW-1:0] CoefYG = 18'sd129;
    localparam logic signed [SumW-1:0] CoefYB = 18'sd25;
    localparam logic signed [SumW-1:0] CoefUR = -18'sd38;
    localparam logic signed [SumW-1:0] CoefUG = -18'sd74;
    localparam logic signed [SumW-1:0] CoefUB = 18'sd112;
    localparam logic signed [SumW-1:0] CoefVR = 18'sd112;
    localparam logic signed [SumW-1:0] CoefVG = -18'sd94;
    localparam logic signed [SumW-1:0] CoefVB = -18'sd18;
    localparam logic signed [SumW-1:0] RoundHalf = 18'sd128;

    // Output offsets
    localparam logic [PixW-1:0] LumaBias   = 8'd16;
    localparam logic [PixW-1:0] ChromaBias = 8'd128;

endpackage

/* rtl/b2n_csc.sv */
// ----------------------------------------------------------------------------
// b2n_csc
// Color space conversion of one BGR pixel to Y, U and V (BT.601, video
// range) with rounding and arithmetic shift. Pure combinational logic.
// ----------------------------------------------------------------------------
module b2n_csc (
    input  logic [b2n_pkg::PixW-1:0] blue,
    input  logic [b2n_pkg::PixW-1:0] green,
    input  logic [b2n_pkg::PixW-1:0] red,
    output logic [b2n_pkg::PixW-1:0] luma,
    output logic [b2n_pkg::PixW-1:0] chroma_u,
    output logic [b2n_pkg::PixW-1:0] chroma_v
);

    logic signed [b2n_pkg::SumW-1:0] blue_s;
    logic signed [b2n_pkg::SumW-1:0] green_s;
    logic signed [b2n_pkg::SumW-1:0] red_s;
    logic signed [b2n_pkg::SumW-1:0] y_sum;
    logic signed [b2n_pkg::SumW-1:0] u_sum;
    logic signed [b2n_pkg::SumW-1:0] v_sum;
    logic signed [b2n_pkg::SumW-1:0] y_shift;
    logic signed [b2n_pkg::SumW-1:0] u_shift;
    logic signed [b2n_pkg::SumW-1:0] v_shift;

    // Zero-extend the components into the signed sum width
    assign blue_s  = {{(b2n_pkg::SumW-b2n_pkg::PixW){1'b0}}, blue};
    assign green_s = {{(b2n_pkg::SumW-b2n_pkg::PixW){1'b0}}, green};
    assign red_s   = {{(b2n_pkg::SumW-b2n_pkg::PixW){1'b0}}, red};

    // Weighted sums with the rounding half added
    assign y_sum = b2n_pkg::CoefYR * red_s + b2n_pkg::CoefYG * green_s
                 + b2n_pkg::CoefYB * blue_s + b2n_pkg::RoundHalf;
    assign u_sum = b2n_pkg::CoefUR * red_s + b2n_pkg::CoefUG * green_s
                 + b2n_pkg::CoefUB * blue_s + b2n_pkg::RoundHalf;
    assign v_sum = b2n_pkg::CoefVR * red_s + b2n_pkg::CoefVG * green_s
                 + b2n_pkg::CoefVB * blue_s + b2n_pkg::RoundHalf;

    // Floor divide by 256, then add the bias and keep eight bits
    assign y_shift = y_sum >>> 8;
    assign u_shift = u_sum >>> 8;
    assign v_shift = v_sum >>> 8;

    assign luma     = y_shift[b2n_pkg::PixW-1:0] + b2n_pkg::LumaBias;
    assign chroma_u = u_shift[b2n_pkg::PixW-1:0] + b2n_pkg::ChromaBias;
    assign chroma_v = v_shift[b2n_pkg::PixW-1:0] + b2n_pkg::ChromaBias;

endmodule

/* rtl/bgr_to_nv12_converter.sv */
// A result is loaded into the output register when its pixel request is accepted.
// Throughput: one pixel per cycle; the single output register sets the rate,
// and a new pixel is taken whenever that register is empty or being drained.
// Reset (rst_n low, asynchronous): position and plane offsets go to zero,
// frame size returns to 1920 x 1080, the output register is emptied.
// ----------------------------------------------------------------------------
// bgr_to_nv12_converter
// Streams BGR pixels in raster order and emits Y with its luma-plane offset
// and, on even rows and columns, U/V with their interleaved UV-plane offset.
// ----------------------------------------------------------------------------
module bgr_to_nv12_converter #(
    parameter int MAX_DIM = b2n_pkg::MaxDimDefault
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [b2n_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [b2n_pkg::CfgDataW-1:0]     cfg_data,

    // Pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]

    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // luma[7:0], luma_addr[31:8], chroma_u[39:32],
                                   // chroma_v[47:40], chroma_addr[70:48], zero[71]
    output logic        m_tuser,   // chroma_valid[0]
    output logic        m_tlast    // frame_end
);

    localparam int CntW = $clog2(MAX_DIM);
    localparam int DimW = $clog2(MAX_DIM + 1);
    localparam int CmpW = (DimW > b2n_pkg::CfgDataW) ? DimW : b2n_pkg::CfgDataW;
    localparam int PixW = b2n_pkg::PixW;
    localparam int LaW  = b2n_pkg::LumaAddrW;
    localparam int CaW  = b2n_pkg::ChromaAddrW;

    // Configuration registers
    logic [b2n_pkg::CfgDataW-1:0] frame_width_reg;
    logic [b2n_pkg::CfgDataW-1:0] frame_height_reg;

    // Position state
    logic [CntW-1:0] col_reg, col_next;
    logic [CntW-1:0] row_reg, row_next;
    logic [LaW-1:0]  luma_off_reg, luma_off_next;
    logic [CaW-1:0]  chroma_off_reg, chroma_off_next;

    // Output register
    logic            out_valid_reg;
    logic [PixW-1:0] luma_reg;
    logic [LaW-1:0]  luma_addr_reg;
    logic            chroma_valid_reg;
    logic [PixW-1:0] chroma_u_reg;
    logic [PixW-1:0] chroma_v_reg;
    logic [CaW-1:0]  chroma_addr_reg;
    logic            frame_end_reg;

    logic            s_accept;
    logic [CmpW-1:0] width_masked;
    logic [CmpW-1:0] height_ext;
    logic [CmpW-1:0] eff_width;
    logic [CmpW-1:0] eff_height;
    logic            last_col;
    logic            last_row;
    logic            chroma_pos;
    logic [PixW-1:0] csc_luma;
    logic [PixW-1:0] csc_u;
    logic [PixW-1:0] csc_v;

    // Accept a pixel request when the output register is free or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Store register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= b2n_pkg::FrameWidthReset;
            frame_height_reg <= b2n_pkg::FrameHeightReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                b2n_pkg::RegFrameWidth:  frame_width_reg  <= cfg_data;
                b2n_pkg::RegFrameHeight: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Round the width down to a multiple of 16 and clamp the frame size to the supported range
    always_comb
    begin
        width_masked = CmpW'({frame_width_reg[b2n_pkg::CfgDataW-1:4], 4'b0000});
        height_ext   = CmpW'(frame_height_reg);
        if (width_masked < CmpW'(16))
            eff_width = CmpW'(16);
        else if (width_masked > CmpW'(MAX_DIM))
            eff_width = CmpW'(MAX_DIM);
        else
            eff_width = width_masked;
        if (height_ext < CmpW'(1))
            eff_height = CmpW'(1);
        else if (height_ext > CmpW'(MAX_DIM))
            eff_height = CmpW'(MAX_DIM);
        else
            eff_height = height_ext;
    end

    assign last_col   = CmpW'(col_reg) >= (eff_width - CmpW'(1));
    assign last_row   = CmpW'(row_reg) >= (eff_height - CmpW'(1));
    assign chroma_pos = !col_reg[0] && !row_reg[0];

    // Advance the raster position and plane offsets
    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        luma_off_next   = luma_off_reg;
        chroma_off_next = chroma_off_reg;
        if (s_accept)
        begin
            luma_off_next = luma_off_reg + LaW'(1);
            if (chroma_pos)
                chroma_off_next = chroma_off_reg + CaW'(2);
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next        = '0;
                    luma_off_next   = '0;
                    chroma_off_next = '0;
                end
                else
                begin
                    row_next = row_reg + CntW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CntW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            luma_off_reg   <= '0;
            chroma_off_reg <= '0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            luma_off_reg   <= luma_off_next;
            chroma_off_reg <= chroma_off_next;
        end
    end

    // Color conversion
    b2n_csc u_csc (
        .blue     (s_tdata[7:0]),
        .green    (s_tdata[15:8]),
        .red      (s_tdata[23:16]),
        .luma     (csc_luma),
        .chroma_u (csc_u),
        .chroma_v (csc_v)
    );

    // Hold the output valid until the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Load the result payload on each accepted request
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            luma_reg         <= csc_luma;
            luma_addr_reg    <= luma_off_reg;
            chroma_valid_reg <= chroma_pos;
            chroma_u_reg     <= chroma_pos ? csc_u : '0;
            chroma_v_reg     <= chroma_pos ? csc_v : '0;
            chroma_addr_reg  <= chroma_pos ? chroma_off_reg : '0;
            frame_end_reg    <= last_col && last_row;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, chroma_addr_reg, chroma_v_reg, chroma_u_reg,
                       luma_addr_reg, luma_reg};
    assign m_tuser  = chroma_valid_reg;
    assign m_tlast  = frame_end_reg;

`ifndef SYNTHESIS
    // An accepted request always leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> m_tvalid)
    else $error("accepted pixel produced no result");

    // The last pixel of a frame returns the position to the frame start
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && last_col && last_row |=>
            col_reg == '0 && row_reg == '0 && luma_off_reg == '0 && chroma_off_reg == '0)
    else $error("position not reset after frame end");

    // Inside a frame the luma offset steps by one per pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && !(last_col && last_row) |=>
            luma_off_reg == $past(luma_off_reg) + LaW'(1))
    else $error("luma offset did not advance by one");

    // Without chroma, the chroma fields of a result are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            chroma_u_reg == '0 && chroma_v_reg == '0 && chroma_addr_reg == '0)
    else $error("chroma fields set on a luma-only result");
`endif

endmodule

/* bench/bgr_to_nv12_converter_tb.sv */
// ----------------------------------------------------------------------------
// bgr_to_nv12_converter_tb
// Drives BGR pixel requests into the converter and predicts Y, U/V, both plane
// offsets and the frame-end flag for each one. Covers color extremes, frame
// size clamping and rounding, size changes in the middle of a frame and
// random streams with random stalls on both sides.
// ----------------------------------------------------------------------------
module bgr_to_nv12_converter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM        = b2n_pkg::MaxDimDefault;
    localparam int RESULT_LATENCY = 1;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PRINT_LIMIT    = 50;

    // Indexes that map to no register
    localparam logic [b2n_pkg::CfgIndexW-1:0] RegUnusedA = 2'd2;
    localparam logic [b2n_pkg::CfgIndexW-1:0] RegUnusedB = 2'd3;

    typedef struct packed {
        logic [b2n_pkg::PixW-1:0]        luma;
        logic [b2n_pkg::LumaAddrW-1:0]   luma_addr;
        logic                            chroma_valid;
        logic [b2n_pkg::PixW-1:0]        chroma_u;
        logic [b2n_pkg::PixW-1:0]        chroma_v;
        logic [b2n_pkg::ChromaAddrW-1:0] chroma_addr;
        logic                            frame_end;
    } nv12_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [b2n_pkg::CfgIndexW-1:0] cfg_index = '0;
    logic [b2n_pkg::CfgDataW-1:0]  cfg_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [23:0]                   s_tdata = '0;   // blue[7:0], green[15:8], red[23:16]
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [71:0]                   m_tdata;        // luma, luma_addr, chroma_u, chroma_v,
                                                   // chroma_addr, zero (lowest bit up)
    logic                          m_tuser;        // chroma_valid
    logic                          m_tlast;        // frame_end

    // Predicted state of the converter
    logic [b2n_pkg::CfgDataW-1:0]    width_reg  = b2n_pkg::FrameWidthReset;
    logic [b2n_pkg::CfgDataW-1:0]    height_reg = b2n_pkg::FrameHeightReset;
    int                              pos_col = 0;
    int                              pos_row = 0;
    logic [b2n_pkg::LumaAddrW-1:0]   luma_next = '0;
    logic [b2n_pkg::ChromaAddrW-1:0] chroma_next = '0;

    nv12_result_t pending_pixels[$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           send_idle = 1'b1;
    bit           recv_idle = 1'b1;
    bit           pixel_offered = 1'b0;

    bgr_to_nv12_converter #(
        .MAX_DIM(MAX_DIM)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("bgr_to_nv12_converter: mismatch");
            $finish;
        end
    end

    // ((sum + 128) >> 8) + bias with a floor shift, kept to 8 bits
    function automatic logic [b2n_pkg::PixW-1:0] round_bias(input int sum,
                                                            input int bias);
        int scaled;
        scaled = (sum + 128) >>> 8;
        return b2n_pkg::PixW'(scaled + bias);
    endfunction

    // Compute the result of one pixel and advance the raster position
    function automatic nv12_result_t convert_pixel(input logic [b2n_pkg::PixW-1:0] blue,
                                                   input logic [b2n_pkg::PixW-1:0] green,
                                                   input logic [b2n_pkg::PixW-1:0] red);
        nv12_result_t res;
        int  ib;
        int  ig;
        int  ir;
        int  width_eff;
        int  height_eff;
        bit  last_col;
        bit  last_row;
        ib = int'(blue);
        ig = int'(green);
        ir = int'(red);
        width_eff = int'(width_reg & 13'h1FF0);
        if (width_eff < 16) width_eff = 16;
        if (width_eff > MAX_DIM) width_eff = MAX_DIM;
        height_eff = int'(height_reg);
        if (height_eff < 1) height_eff = 1;
        if (height_eff > MAX_DIM) height_eff = MAX_DIM;
        last_col = pos_col >= width_eff - 1;
        last_row = pos_row >= height_eff - 1;

        res = '0;
        res.luma = round_bias(66 * ir + 129 * ig + 25 * ib, 16);
        res.luma_addr = luma_next;
        res.chroma_valid = (pos_row % 2 == 0) && (pos_col % 2 == 0);
        if (res.chroma_valid)
        begin
            res.chroma_u = round_bias(-38 * ir - 74 * ig + 112 * ib, 128);
            res.chroma_v = round_bias(112 * ir - 94 * ig - 18 * ib, 128);
            res.chroma_addr = chroma_next;
            chroma_next = chroma_next + 2'd2;
        end
        res.frame_end = last_col && last_row;

        luma_next = luma_next + 1'b1;
        if (last_col)
        begin
            pos_col = 0;
            if (last_row)
            begin
                pos_row = 0;
                luma_next = '0;
                chroma_next = '0;
            end
            else
            begin
                pos_row++;
            end
        end
        else
        begin
            pos_col++;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ns: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Compare one accepted result against the oldest prediction
    task automatic check_result();
        nv12_result_t want;
        if (pending_pixels.size() == 0)
        begin
            report_mismatch($sformatf("result with no pixel pending: tdata 0x%0h",
                                      m_tdata));
            return;
        end
        want = pending_pixels.pop_front();
        compare_field("luma",         m_tdata[7:0],   want.luma);
        compare_field("luma_addr",    m_tdata[31:8],  want.luma_addr);
        compare_field("chroma_u",     m_tdata[39:32], want.chroma_u);
        compare_field("chroma_v",     m_tdata[47:40], want.chroma_v);
        compare_field("chroma_addr",  m_tdata[70:48], want.chroma_addr);
        compare_field("tdata pad",    m_tdata[71],    1'b0);
        compare_field("chroma_valid", m_tuser,        want.chroma_valid);
        compare_field("frame_end",    m_tlast,        want.frame_end);
    endtask

    // Accept results with random stalls
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = recv_idle ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            check_result();
        end
    end

    // Offer one pixel request after a random gap and predict its result
    task automatic send_pixel(input logic [b2n_pkg::PixW-1:0] blue,
                              input logic [b2n_pkg::PixW-1:0] green,
                              input logic [b2n_pkg::PixW-1:0] red);
        int gap;
        gap = send_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            if (pixel_offered)
            begin
                s_tvalid <= 1'b0;
                pixel_offered = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {red, green, blue};
        pixel_offered = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_pixels.push_back(convert_pixel(blue, green, red));
    endtask

    // Hold off pixels until every pending result is back
    task automatic wait_for_drain();
        if (pixel_offered)
        begin
            s_tvalid <= 1'b0;
            pixel_offered = 1'b0;
        end
        while (pending_pixels.size() != 0) @(posedge clk);
    endtask

    // Write a register once the converter is idle
    task automatic write_reg(input logic [b2n_pkg::CfgIndexW-1:0] index,
                             input logic [b2n_pkg::CfgDataW-1:0] value);
        wait_for_drain();
        repeat (RESULT_LATENCY + 1) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (index == b2n_pkg::RegFrameWidth)
            width_reg = value;
        else if (index == b2n_pkg::RegFrameHeight)
            height_reg = value;
    endtask

    // Random component, biased toward the extremes
    function automatic logic [b2n_pkg::PixW-1:0] rand_component();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return b2n_pkg::PixW'($urandom);
        endcase
    endfunction

    // Set a frame size, then stream random pixels
    task automatic run_phase(input int width, input int height, input int count,
                             input bit pause_mid);
        write_reg(b2n_pkg::RegFrameWidth, b2n_pkg::CfgDataW'(width));
        write_reg(b2n_pkg::RegFrameHeight, b2n_pkg::CfgDataW'(height));
        send_idle = $urandom_range(0, 3) != 0;
        recv_idle = $urandom_range(0, 3) != 0;
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
                wait_for_drain();
            send_pixel(rand_component(), rand_component(), rand_component());
        end
    endtask

    // Corners of the color cube, each on an even and an odd column
    task automatic test_color_corners();
        int k;
        for (int i = 0; i < 16; i++)
        begin
            k = (i % 2 == 0) ? i / 2 : 7 - i / 2;
            send_pixel(k[0] ? 8'hFF : 8'h00, k[1] ? 8'hFF : 8'h00, k[2] ? 8'hFF : 8'h00);
        end
    endtask

    // Shrink the frame under the current position: next pixel ends the frame
    task automatic test_resize_mid_frame();
        write_reg(b2n_pkg::RegFrameHeight, b2n_pkg::CfgDataW'(1));
        write_reg(b2n_pkg::RegFrameWidth, b2n_pkg::CfgDataW'(16));
        send_pixel(8'h80, 8'h40, 8'hC0);
        send_pixel(8'h12, 8'hED, 8'h5A);
        send_pixel(8'hA5, 8'h3C, 8'h7E);
    endtask

    // Writes to unmapped indexes must leave the frame size alone
    task automatic test_unused_index();
        write_reg(RegUnusedA, 13'h1FFF);
        write_reg(RegUnusedB, 13'h0AAA);
        repeat (4) send_pixel(rand_component(), rand_component(), rand_component());
    endtask

    task automatic test_size_clamps();
        run_phase(0, 0, 50, 1'b0);
        run_phase(8191, 8191, 40, 1'b0);
        run_phase(8176, 0, 40, 1'b0);
        run_phase(17, 2, 70, 1'b0);
        run_phase(31, 3, 60, 1'b1);
    endtask

    task automatic test_large_frames();
        run_phase(4096, 1, 30, 1'b0);
        run_phase(16, 4096, 60, 1'b0);
        run_phase(4096, 4096, 40, 1'b0);
        run_phase(int'(b2n_pkg::FrameWidthReset), int'(b2n_pkg::FrameHeightReset),
                  40, 1'b0);
    endtask

    task automatic test_small_frames();
        run_phase(16, 1, 40, 1'b1);
        run_phase(32, 3, 100, 1'b0);
        run_phase(48, 5, 200, 1'b1);
        run_phase(64, 2, 130, 1'b0);
        run_phase(33, 1, 80, 1'b0);
    endtask

    task automatic test_random_sizes();
        repeat (3)
            run_phase($urandom_range(1, 6) * 16 + $urandom_range(0, 15),
                      $urandom_range(1, 6), $urandom_range(30, 60), 1'(($urandom_range(0, 1))));
    endtask

    // Main sequence
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_color_corners();
        test_resize_mid_frame();
        test_unused_index();
        test_size_clamps();
        test_large_frames();
        test_small_frames();
        test_random_sizes();

        wait_for_drain();
        repeat (RESULT_LATENCY + 4) @(posedge clk);
        if (error_count == 0)
            $display("bgr_to_nv12_converter: match");
        else
            $display("bgr_to_nv12_converter: mismatch");
        $finish;
    end

endmodule
